>>> design/icm_pixel_label_search_assert.svh
// Assertion macros used by the pixel label search top level.
`ifndef ICM_PIXEL_LABEL_SEARCH_ASSERT_SVH
`define ICM_PIXEL_LABEL_SEARCH_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ICM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ICM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/icm_pls_pkg.sv
// Shared types, constants and helper functions of the pixel label search.
`timescale 1ns / 1ps
package icm_pls_pkg;
    localparam int LABEL_W    = 8;
    localparam int ENERGY_W   = 25;
    localparam int LAMBDA_W   = 8;
    localparam int PSI_W      = 16;
    localparam int SQ_W       = 16;
    localparam int NB_FIELDS  = 8;
    localparam int CNT_W      = 4;
    localparam int LANES      = 16;
    localparam int LANE_W     = 4;
    localparam int GRP_W      = LABEL_W - LANE_W;
    localparam int FRAC_BITS  = 4;
    localparam int SUM_W      = SQ_W + 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_NEIGHBORS_DEF = 8;
    localparam int LABEL_COUNT_DEF   = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PSI    = 4'd1;

    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 8'd8;
    localparam logic [PSI_W-1:0]    PSI_RESET    = 16'd1;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [GRP_W-1:0] grp;
    } t_ctl;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [LABEL_W-1:0] a,
                                                input logic [LABEL_W-1:0] b);
        logic [LABEL_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction
endpackage

>>> design/icm_pls_energy.sv
// Energy lanes: squared differences, capping, weighting and summing for 16 labels.
`timescale 1ns / 1ps
module icm_pls_energy
    import icm_pls_pkg::*;
#(
    parameter int LABEL_COUNT = LABEL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  t_ctl                i_ctl,
    input  logic [LABEL_W-1:0]  i_base,
    input  logic [NB_FIELDS-1:0] i_nmask,
    input  logic [LABEL_W-1:0]  i_nb [NB_FIELDS],
    input  logic [LAMBDA_W-1:0] i_lambda,
    input  logic [PSI_W-1:0]    i_psi,
    output t_ctl                o_ctl,
    output logic [ENERGY_W-1:0] o_energy [LANES]
);
    t_ctl               r1_ctl;
    logic [SQ_W-1:0]    r1_d2  [LANES];
    logic [SQ_W-1:0]    r1_cap [LANES][NB_FIELDS];
    logic [LANES-1:0]   r1_ok;
    t_ctl               r2_ctl;
    logic [ENERGY_W-1:0] r2_e  [LANES];

    logic [SQ_W-1:0]    n1_d2  [LANES];
    logic [SQ_W-1:0]    n1_cap [LANES][NB_FIELDS];
    logic [LANES-1:0]   n1_ok;
    logic [ENERGY_W-1:0] n2_e  [LANES];

    // Stage one: per lane label, squared distances and the cap.
    always_comb begin
        logic [LABEL_W-1:0] lbl;
        logic [SQ_W-1:0]    t;
        for (int l = 0; l < LANES; l++) begin
            lbl      = {i_ctl.grp, LANE_W'(l)};
            n1_ok[l] = (int'(lbl) < LABEL_COUNT);
            n1_d2[l] = sq_diff(i_base, lbl);
            for (int k = 0; k < NB_FIELDS; k++) begin
                t = sq_diff(i_nb[k], lbl);
                n1_cap[l][k] = !i_nmask[k] ? '0 : ((t < i_psi) ? t : i_psi);
            end
        end
    end

    // Stage two: weighted data term plus the scaled neighbour sum; lanes beyond the label range read all ones.
    always_comb begin
        logic [SUM_W-1:0] s;
        for (int l = 0; l < LANES; l++) begin
            s = '0;
            for (int k = 0; k < NB_FIELDS; k++) begin
                s = s + SUM_W'(r1_cap[l][k]);
            end
            n2_e[l] = r1_ok[l]
                ? (ENERGY_W'(ENERGY_W'(i_lambda) * ENERGY_W'(r1_d2[l]))
                   + (ENERGY_W'(s) << FRAC_BITS))
                : '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
            r2_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_d2  <= n1_d2;
            r1_cap <= n1_cap;
            r1_ok  <= n1_ok;
            r2_e   <= n2_e;
        end
    end

    assign o_ctl    = r2_ctl;
    assign o_energy = r2_e;
endmodule

>>> design/icm_pls_min.sv
// Minimum search: registered tree over the lanes and a running best across groups.
`timescale 1ns / 1ps
module icm_pls_min
    import icm_pls_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  logic [ENERGY_W-1:0] i_energy [LANES],
    input  logic                i_stall,
    output logic                o_adv,
    output logic                o_valid,
    output logic [LABEL_W-1:0]  o_label,
    output logic [ENERGY_W-1:0] o_energy
);
    localparam int QUADS = LANES / 4;

    t_ctl                r3_ctl;
    logic [ENERGY_W-1:0] r3_e   [QUADS];
    logic [LANE_W-1:0]   r3_idx [QUADS];
    t_ctl                r4_ctl;
    logic [ENERGY_W-1:0] r4_e;
    logic [LABEL_W-1:0]  r4_lbl;
    logic [ENERGY_W-1:0] r_best_e;
    logic [LABEL_W-1:0]  r_best_lbl;
    logic                r_out_valid;
    logic [ENERGY_W-1:0] r_out_e;
    logic [LABEL_W-1:0]  r_out_lbl;

    logic [ENERGY_W-1:0] n3_e   [QUADS];
    logic [LANE_W-1:0]   n3_idx [QUADS];
    logic [ENERGY_W-1:0] n4_e;
    logic [LANE_W-1:0]   n4_idx;
    logic                take;
    logic [ENERGY_W-1:0] m_e;
    logic [LABEL_W-1:0]  m_lbl;
    logic                fin;

    // Ties keep the earlier entry, so the lowest label wins throughout.
    always_comb begin
        for (int q = 0; q < QUADS; q++) begin
            n3_e[q]   = i_energy[4*q];
            n3_idx[q] = LANE_W'(4*q);
            for (int j = 1; j < 4; j++) begin
                if (i_energy[4*q+j] < n3_e[q]) begin
                    n3_e[q]   = i_energy[4*q+j];
                    n3_idx[q] = LANE_W'(4*q+j);
                end
            end
        end
        n4_e   = r3_e[0];
        n4_idx = r3_idx[0];
        for (int q = 1; q < QUADS; q++) begin
            if (r3_e[q] < n4_e) begin
                n4_e   = r3_e[q];
                n4_idx = r3_idx[q];
            end
        end
    end

    // The first group starts the running best; later groups must be strictly lower.
    assign take  = r4_ctl.first || (r4_e < r_best_e);
    assign m_e   = take ? r4_e   : r_best_e;
    assign m_lbl = take ? r4_lbl : r_best_lbl;

    assign o_adv = !(r4_ctl.valid && r4_ctl.last && r_out_valid && i_stall);
    assign fin   = r4_ctl.valid && r4_ctl.last && o_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl.valid <= 1'b0;
            r4_ctl.valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_adv) begin
                r3_ctl <= i_ctl;
                r4_ctl <= r3_ctl;
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r3_e   <= n3_e;
            r3_idx <= n3_idx;
            r4_e   <= n4_e;
            r4_lbl <= {r3_ctl.grp, n4_idx};
            if (r4_ctl.valid) begin
                r_best_e   <= m_e;
                r_best_lbl <= m_lbl;
            end
        end
        if (fin) begin
            r_out_e   <= m_e;
            r_out_lbl <= m_lbl;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_label  = r_out_lbl;
    assign o_energy = r_out_e;
endmodule

>>> design/icm_pixel_label_search.sv
// Top level of the pixel label search: item register, group sequencer and registers.
`timescale 1ns / 1ps
`include "icm_pixel_label_search_assert.svh"
// One item (a pixel value with up to eight neighbour values) is scored against
// every label from 0 to LABEL_COUNT-1 with a truncated quadratic energy, and
// the lowest label of least energy is returned with that energy in 4-bit
// fractional fixed point. Labels are scored sixteen at a time: after an item
// is taken, the sequencer feeds ceil(LABEL_COUNT/16) label groups into the
// pipeline one after another, holding while the pipeline stalls, so a new
// item is accepted once the last group of the previous one enters, and the
// sequencer's group walk sets the pace at which items are taken. After its last
// group enters, an item's result passes through two stages of energy lanes,
// two of the minimum tree and the output register. The output register lets the
// next item be taken and worked on while a result waits on o_valid. The
// configuration registers (lambda_q4 at index 0, psi_max at index 1) are
// always ready; writes to other indices are dropped, and writes should only
// be made while no item is in flight.
module icm_pixel_label_search
    import icm_pls_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int LABEL_COUNT   = LABEL_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [LABEL_W-1:0]    i_base_value,
    input  logic [CNT_W-1:0]      i_neighbor_count,
    input  logic [LABEL_W-1:0]    i_neighbor_0,
    input  logic [LABEL_W-1:0]    i_neighbor_1,
    input  logic [LABEL_W-1:0]    i_neighbor_2,
    input  logic [LABEL_W-1:0]    i_neighbor_3,
    input  logic [LABEL_W-1:0]    i_neighbor_4,
    input  logic [LABEL_W-1:0]    i_neighbor_5,
    input  logic [LABEL_W-1:0]    i_neighbor_6,
    input  logic [LABEL_W-1:0]    i_neighbor_7,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LABEL_W-1:0]    o_best_label,
    output logic [ENERGY_W-1:0]   o_min_energy_q4,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int GROUPS = (LABEL_COUNT + LANES - 1) / LANES;
    localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(GROUPS - 1);

    logic [LAMBDA_W-1:0]  r_lambda;
    logic [PSI_W-1:0]     r_psi;
    logic                 r_busy;
    logic [GRP_W-1:0]     r_grp;
    logic [LABEL_W-1:0]   r_base;
    logic [NB_FIELDS-1:0] r_nmask;
    logic [LABEL_W-1:0]   r_nb [NB_FIELDS];

    logic [LABEL_W-1:0]   in_nb [NB_FIELDS];
    logic [NB_FIELDS-1:0] n_nmask;
    logic                 adv;
    logic                 feed_last;
    logic                 accept;
    t_ctl                 feed_ctl;
    t_ctl                 e_ctl;
    logic [ENERGY_W-1:0]  e_energy [LANES];

    assign in_nb = '{i_neighbor_0, i_neighbor_1, i_neighbor_2, i_neighbor_3,
                     i_neighbor_4, i_neighbor_5, i_neighbor_6, i_neighbor_7};

    // A neighbour counts when it lies below both the given count and the
    // configured maximum; larger counts thus saturate.
    always_comb begin
        for (int k = 0; k < NB_FIELDS; k++) begin
            n_nmask[k] = (i_neighbor_count > CNT_W'(k)) && (k < MAX_NEIGHBORS);
        end
    end

    // The item register frees up in the cycle its last group enters the
    // pipeline, so items follow each other without a bubble.
    assign feed_last = r_busy && (r_grp == LAST_GRP) && adv;
    assign o_stall   = r_busy && !feed_last;
    assign accept    = i_valid && !o_stall;

    assign feed_ctl.valid = r_busy;
    assign feed_ctl.first = (r_grp == '0);
    assign feed_ctl.last  = (r_grp == LAST_GRP);
    assign feed_ctl.grp   = r_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_grp  <= '0;
        end else if (feed_last) begin
            r_busy <= 1'b0;
        end else if (r_busy && adv) begin
            r_grp <= r_grp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_base  <= i_base_value;
            r_nmask <= n_nmask;
            r_nb    <= in_nb;
        end
    end

    // Configuration registers; unknown indices are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= LAMBDA_RESET;
            r_psi    <= PSI_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAMBDA: r_lambda <= i_cfg_data[LAMBDA_W-1:0];
                CFG_PSI:    r_psi    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    icm_pls_energy #(
        .LABEL_COUNT(LABEL_COUNT)
    ) u_energy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_ctl    (feed_ctl),
        .i_base   (r_base),
        .i_nmask  (r_nmask),
        .i_nb     (r_nb),
        .i_lambda (r_lambda),
        .i_psi    (r_psi),
        .o_ctl    (e_ctl),
        .o_energy (e_energy)
    );

    icm_pls_min u_min (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (e_ctl),
        .i_energy (e_energy),
        .i_stall  (i_stall),
        .o_adv    (adv),
        .o_valid  (o_valid),
        .o_label  (o_best_label),
        .o_energy (o_min_energy_q4)
    );

    `ICM_ASSERT_NEXT(a_busy_ends_on_last, r_busy && !feed_last && !accept, r_busy, "item dropped before its last group")
    `ICM_ASSERT_NOW(a_grp_in_range, r_busy, r_grp <= LAST_GRP, "label group beyond the label range")
    `ICM_ASSERT_NOW(a_label_in_range, o_valid, int'(o_best_label) < LABEL_COUNT, "best label out of range")
endmodule

>>> tb/icm_label_checker.sv
// Checker for the pixel label search: predicts each result and compares it.
`timescale 1ns / 1ps
module icm_label_checker
    import icm_pls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_stall_in,
    input  logic [LABEL_W-1:0]    i_base_value,
    input  logic [CNT_W-1:0]      i_neighbor_count,
    input  logic [LABEL_W-1:0]    i_nb [NB_FIELDS],
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic [LABEL_W-1:0]    i_best_label,
    input  logic [ENERGY_W-1:0]   i_min_energy_q4,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    typedef struct packed {
        logic [LABEL_W-1:0]  label;
        logic [ENERGY_W-1:0] energy;
    } t_best;

    logic [LAMBDA_W-1:0] lambda_q4;
    logic [PSI_W-1:0]    psi_max;
    t_best               best_q[$];

    // Exhaustive label search, written directly from the energy definition.
    function automatic t_best search_labels(input logic [LABEL_W-1:0] base,
                                            input logic [CNT_W-1:0] cnt_in,
                                            input logic [LABEL_W-1:0] nb [NB_FIELDS]);
        longint unsigned smooth, energy, d, t, best_e;
        int              cnt;
        t_best           r;
        cnt = (cnt_in > NB_FIELDS) ? NB_FIELDS : int'(cnt_in);
        best_e = 0;
        r = '0;
        for (int x = 0; x < 256; x++) begin
            smooth = 0;
            for (int i = 0; i < cnt; i++) begin
                d = (nb[i] >= x) ? nb[i] - x : x - nb[i];
                t = d * d;
                smooth += (t < psi_max) ? t : psi_max;
            end
            d = (base >= x) ? base - x : x - base;
            energy = lambda_q4 * d * d + (smooth << FRAC_BITS);
            if (energy > 64'h1FFFFFF) energy = 64'h1FFFFFF;
            if (x == 0 || energy < best_e) begin
                best_e = energy;
                r.label = LABEL_W'(x);
                r.energy = ENERGY_W'(energy);
            end
        end
        return r;
    endfunction

    assign o_pending = best_q.size();

    always @(posedge i_clk) begin
        t_best e;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            lambda_q4 <= LAMBDA_RESET;
            psi_max <= PSI_RESET;
            o_fail_count <= 0;
            best_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LAMBDA) lambda_q4 <= i_cfg_data[LAMBDA_W-1:0];
                else if (i_cfg_index == CFG_PSI) psi_max <= i_cfg_data;
            end
            if (i_valid && !i_stall_in)
                best_q.push_back(search_labels(i_base_value, i_neighbor_count, i_nb));
            if (i_res_valid && !i_res_stall) begin
                if (best_q.size() == 0) begin
                    $error("result with no item outstanding");
                    errs += 1;
                end else begin
                    e = best_q.pop_front();
                    if (e.label !== i_best_label) begin
                        $error("best_label expected %0d got %0d", e.label, i_best_label);
                        errs += 1;
                    end
                    if (e.energy !== i_min_energy_q4) begin
                        $error("min_energy_q4 expected %0d got %0d", e.energy,
                               i_min_energy_q4);
                        errs += 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

>>> tb/testbench.sv
// Top of the pixel label search testbench: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module testbench;
    import icm_pls_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [LABEL_W-1:0]    i_base_value = '0;
    logic [CNT_W-1:0]      i_neighbor_count = '0;
    logic [LABEL_W-1:0]    nb [NB_FIELDS];
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [LABEL_W-1:0]    o_best_label;
    logic [ENERGY_W-1:0]   o_min_energy_q4;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    bit                    stalls_on = 1'b1;

    localparam int CYCLE_LIMIT = 400000;

    initial foreach (nb[i]) nb[i] = '0;

    always #2 i_clk = ~i_clk;

    icm_pixel_label_search uut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_base_value, .i_neighbor_count,
        .i_neighbor_0(nb[0]), .i_neighbor_1(nb[1]), .i_neighbor_2(nb[2]),
        .i_neighbor_3(nb[3]), .i_neighbor_4(nb[4]), .i_neighbor_5(nb[5]),
        .i_neighbor_6(nb[6]), .i_neighbor_7(nb[7]),
        .o_valid, .i_stall, .o_best_label, .o_min_energy_q4,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    icm_label_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_base_value,
        .i_neighbor_count, .i_nb(nb), .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_best_label(o_best_label), .i_min_energy_q4(o_min_energy_q4),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // The result side stalls at random, except while stalling is switched off.
    always @(negedge i_clk) begin
        if (stalls_on && $urandom_range(0, 3) == 0) i_stall <= 1'b1;
        else i_stall <= 1'b0;
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Presents one item and holds it until the block takes it. Valid is left
    // high afterwards; the next call (when it draws a gap), a register write or the end drops it.
    task automatic send_item(input logic [7:0] base, input logic [3:0] cnt,
                             input logic [7:0] vals [NB_FIELDS]);
        int g;
        g = gap_length();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_base_value <= base;
        i_neighbor_count <= cnt;
        foreach (nb[i]) nb[i] <= vals[i];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits for all results, lets the pipeline drain, then writes a register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        logic [7:0] vals [NB_FIELDS];
        logic [7:0] base;
        base = 8'($urandom);
        // Neighbours are often close to the pixel so that the cap matters both ways.
        foreach (vals[i])
            vals[i] = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                  : 8'(base + $urandom_range(0, 20) - 10);
        send_item(base, 4'($urandom_range(0, 15)), vals);
    endtask

    initial begin
        logic [7:0] v [NB_FIELDS];
        logic [15:0] psi_set [5];
        logic [7:0]  lam_set [5];
        psi_set = '{16'd1, 16'd0, 16'hFFFF, 16'd65025, 16'd400};
        lam_set = '{8'd8, 8'd0, 8'hFF, 8'd16, 8'd3};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at reset settings: extremes, no neighbours, oversized count.
        foreach (v[i]) v[i] = 8'd0;
        send_item(8'd0, 4'd0, v);
        send_item(8'd255, 4'd0, v);
        foreach (v[i]) v[i] = 8'd255;
        send_item(8'd0, 4'd8, v);
        send_item(8'd128, 4'd15, v);
        foreach (v[i]) v[i] = (i % 2) ? 8'd255 : 8'd0;
        send_item(8'd100, 4'd8, v);
        send_item(8'hAA, 4'd9, v);
        foreach (v[i]) v[i] = 8'h55;
        send_item(8'h55, 4'd4, v);
        // Zero lambda: no neighbours gives label zero, energy zero; ties on neighbours.
        write_reg(CFG_LAMBDA, 16'd0);
        send_item(8'd200, 4'd0, v);
        foreach (v[i]) v[i] = (i % 2) ? 8'd10 : 8'd20;
        send_item(8'd200, 4'd2, v);
        write_reg(CFG_PSI, 16'hFFFF);
        send_item(8'd200, 4'd2, v);
        send_item(8'd0, 4'd8, v);
        write_reg(CFG_LAMBDA, 16'hFFFF);
        foreach (v[i]) v[i] = 8'd255;
        send_item(8'd0, 4'd8, v);
        write_reg(CFG_PSI, 16'd0);
        send_item(8'd77, 4'd8, v);
        write_reg(4'd7, 16'd1234);
        send_item(8'd77, 4'd3, v);

        // Random phases across register settings.
        for (int p = 0; p < 10; p++) begin
            write_reg(CFG_LAMBDA, (p < 5) ? 16'(lam_set[p]) : 16'($urandom));
            write_reg(CFG_PSI, (p < 5) ? psi_set[p] : 16'($urandom_range(0, 65535)));
            stalls_on = (p % 3) != 2;
            repeat (95) random_item();
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
